>>> design/zstring_text_decoder_defines.svh
// ============================================================================
// Assertion macros for the packed text word decoder
// Shared check forms used by the decoder's modules.
// ============================================================================
`ifndef ZSTRING_TEXT_DECODER_DEFINES_SVH
`define ZSTRING_TEXT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ZSTD_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("zstd check failed");

// Next-cycle implication, disabled while reset is held.
`define ZSTD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("zstd check failed");

`endif

>>> design/zstd_pkg.sv
// ============================================================================
// zstd_pkg
// Types and code constants shared by the packed text word decoder.
// ============================================================================
package zstd_pkg;

    // Result kinds as they appear on the output port.
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ALPHA   = 3'd1,
        KIND_LITERAL = 3'd2,
        KIND_NEWLINE = 3'd3,
        KIND_SPACE   = 3'd4,
        KIND_ABBREV  = 3'd5
    } t_kind;

    // Special code values.
    localparam logic [4:0] CODE_SPACE      = 5'd0;
    localparam logic [4:0] CODE_ABBREV_MAX = 5'd3;
    localparam logic [4:0] CODE_SHIFT_MAX  = 5'd5;
    localparam logic [4:0] CODE_SHIFT_BASE = 5'd3;
    localparam logic [4:0] CODE_ABBREV_LO  = 5'd1;
    localparam logic [4:0] CODE_LITERAL    = 5'd6;
    localparam logic [4:0] CODE_NEWLINE    = 5'd7;

    // Character sets.
    localparam logic [1:0] SET_0   = 2'd0;
    localparam logic [1:0] SET_2   = 2'd2;
    localparam logic [1:0] SET_RSV = 2'd3;

    // Literal sequencing.
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_HIGH = 2'd1;
    localparam logic [1:0] PHASE_LOW  = 2'd2;

    localparam int unsigned ALPHA_LEN = 26;

    // Result slots per word.
    localparam int unsigned CODES_PER_WORD = 3;
    localparam logic [1:0]  SLOT_LAST      = 2'd2;

    // Decoder state of one context.
    typedef struct packed {
        logic [1:0] temp_shift;
        logic [1:0] lock_shift;
        logic       abbrev_pending;
        logic [1:0] abbrev_bank;
        logic [1:0] literal_phase;
        logic [4:0] literal_high;
    } t_ctx;

    // One decoded result.
    typedef struct packed {
        t_kind      kind;
        logic [9:0] value;
    } t_result;

    // Write-back of a context after a word.
    typedef struct packed {
        logic en;
        logic idx;
        t_ctx ctx;
    } t_ctx_wr;

endpackage

>>> design/zstd_code_step.sv
// ============================================================================
// zstd_code_step
// Decodes one 5-bit code against a context state and gives the next state.
// ============================================================================
module zstd_code_step
    import zstd_pkg::*;
(
    input  t_ctx       i_ctx,
    input  logic [4:0] i_code,
    output t_ctx       o_ctx,
    output t_result    o_res
);

    logic [1:0] set_q;
    logic [1:0] target;
    logic [1:0] locked;
    logic [6:0] alpha;

    always_comb begin
        set_q  = (i_ctx.temp_shift == SET_RSV) ? SET_2 : i_ctx.temp_shift;
        target = 2'(i_code - CODE_SHIFT_BASE);
        locked = (set_q == target) ? set_q : SET_0;
        alpha  = 7'(set_q) * 7'(ALPHA_LEN) + 7'(i_code) - 7'(CODE_LITERAL);

        o_ctx       = i_ctx;
        o_res.kind  = KIND_NONE;
        o_res.value = '0;

        if (i_ctx.abbrev_pending) begin
            o_res.kind           = KIND_ABBREV;
            o_res.value          = 10'({i_ctx.abbrev_bank, i_code});
            o_ctx.abbrev_pending = 1'b0;
            o_ctx.temp_shift     = i_ctx.lock_shift;
        end else if (i_ctx.literal_phase != PHASE_IDLE) begin
            if (i_ctx.literal_phase == PHASE_HIGH) begin
                o_ctx.literal_high  = i_code;
                o_ctx.literal_phase = PHASE_LOW;
            end else begin
                o_res.kind          = KIND_LITERAL;
                o_res.value         = {i_ctx.literal_high, i_code};
                o_ctx.literal_phase = PHASE_IDLE;
                o_ctx.temp_shift    = i_ctx.lock_shift;
            end
        end else if (i_code == CODE_SPACE) begin
            o_res.kind       = KIND_SPACE;
            o_ctx.temp_shift = i_ctx.lock_shift;
        end else if (i_code <= CODE_ABBREV_MAX) begin
            o_ctx.abbrev_pending = 1'b1;
            o_ctx.abbrev_bank    = 2'(i_code - CODE_ABBREV_LO);
        end else if (i_code <= CODE_SHIFT_MAX) begin
            if (set_q == SET_0) begin
                o_ctx.temp_shift = target;
            end else begin
                o_ctx.temp_shift = locked;
                o_ctx.lock_shift = locked;
            end
        end else if (set_q == SET_2 && i_code == CODE_LITERAL) begin
            o_ctx.literal_phase = PHASE_HIGH;
        end else if (set_q == SET_2 && i_code == CODE_NEWLINE) begin
            o_res.kind       = KIND_NEWLINE;
            o_ctx.temp_shift = i_ctx.lock_shift;
        end else begin
            o_res.kind       = KIND_ALPHA;
            o_res.value      = 10'(alpha);
            o_ctx.temp_shift = i_ctx.lock_shift;
        end
    end

endmodule

>>> design/zstd_ctx_regs.sv
// ============================================================================
// zstd_ctx_regs
// Per-context decoder state registers with one read and one write port.
// ============================================================================
module zstd_ctx_regs
    import zstd_pkg::*;
#(
    parameter int NUM_CONTEXTS = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rd_idx,
    output t_ctx    o_rd_ctx,
    input  t_ctx_wr i_wr
);

    t_ctx r_ctx [NUM_CONTEXTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                r_ctx[c] <= '0;
            end
        end else if (i_wr.en) begin
            r_ctx[i_wr.idx] <= i_wr.ctx;
        end
    end

    assign o_rd_ctx = r_ctx[i_rd_idx];

endmodule

>>> design/zstd_out_ser.sv
// ============================================================================
// zstd_out_ser
// Result register for one word, sent out as three results, one per cycle while i_ready is high.
// ============================================================================
`include "zstring_text_decoder_defines.svh"

module zstd_out_ser
    import zstd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res [CODES_PER_WORD],
    input  logic    i_end,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res,
    output logic    o_last,
    output logic    o_end
);

    t_result    r_res [CODES_PER_WORD];
    logic [1:0] r_slot;
    logic       r_busy;
    logic       r_end;
    logic       take_last;

    assign take_last  = r_busy && i_ready && (r_slot == SLOT_LAST);
    assign o_can_load = !r_busy || take_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_slot <= '0;
        end else if (r_busy && i_ready) begin
            if (r_slot == SLOT_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
            r_end <= i_end;
        end
    end

    assign o_valid = r_busy;
    assign o_res   = r_res[r_slot];
    assign o_last  = (r_slot == SLOT_LAST);
    assign o_end   = r_end;

    `ZSTD_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, r_busy, r_slot <= SLOT_LAST)
    `ZSTD_ASSERT_NOW(a_load_ok, i_clk, i_rst_n, i_load, o_can_load)
    `ZSTD_ASSERT_NEXT(a_drain, i_clk, i_rst_n, take_last && !i_load, !r_busy)
    `ZSTD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_busy && !i_ready,
                      r_busy && $stable(r_slot))

endmodule

>>> design/zstring_text_decoder.sv
// ============================================================================
// zstring_text_decoder
// Packed text word decoder: three 5-bit codes per word, one result each.
// ============================================================================
// Usage: a packed text word and its context bit arrive on the input channel
// (i_valid / o_ready). The word is decoded in the cycle it is accepted, using
// the state of the chosen context, and its three results are loaded into a
// result register. They leave on the output channel (o_valid / i_ready), one
// result per cycle while the receiver is ready, high code first, with o_last
// set on the third. The first result is valid in the cycle after acceptance.
// While the receiver takes every result, input words are limited by the
// single result port, which carries one result per cycle. The next word is
// accepted in the same cycle the third result of the previous one is taken,
// so the output runs without gaps.
// When the receiver stalls, the current result holds and o_ready stays low
// until the last result of the pending word is taken.
// Reset (synchronous, active low) clears both contexts' shift, abbreviation
// and literal state and empties the result register.
// A word with bit 15 set is decoded normally, then its context returns to
// the reset state.
// ============================================================================
module zstring_text_decoder
    import zstd_pkg::*;
#(
    parameter int NUM_CONTEXTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_text_word,
    input  logic        i_context_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [9:0]  o_value,
    output logic        o_last,
    output logic        o_string_end
);

    t_ctx    cur_ctx;
    t_ctx    step_ctx [CODES_PER_WORD + 1];
    t_result step_res [CODES_PER_WORD];
    t_ctx_wr ctx_wr;
    t_result out_res;
    logic    accept;
    logic    can_load;

    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    // Context state, read by the incoming word's context bit.
    zstd_ctx_regs #(
        .NUM_CONTEXTS(NUM_CONTEXTS)
    ) u_ctx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (i_context_req),
        .o_rd_ctx (cur_ctx),
        .i_wr     (ctx_wr)
    );

    // Three code decoders in a chain; slot 0 takes bits 14..10.
    assign step_ctx[0] = cur_ctx;

    for (genvar k = 0; k < CODES_PER_WORD; k++) begin : g_step
        zstd_code_step u_step (
            .i_ctx  (step_ctx[k]),
            .i_code (i_text_word[14 - 5*k -: 5]),
            .o_ctx  (step_ctx[k + 1]),
            .o_res  (step_res[k])
        );
    end

    // The final state goes back to the context, or reset state at string end.
    always_comb begin
        ctx_wr.en  = accept;
        ctx_wr.idx = i_context_req;
        ctx_wr.ctx = i_text_word[15] ? t_ctx'('0) : step_ctx[CODES_PER_WORD];
    end

    zstd_out_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (step_res),
        .i_end      (i_text_word[15]),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res),
        .o_last     (o_last),
        .o_end      (o_string_end)
    );

    assign o_kind  = 3'(out_res.kind);
    assign o_value = out_res.value;

endmodule

>>> bench/zstring_text_decoder_tb.sv
// ============================================================================
// Testbench for the packed text word decoder
// Drives packed text words on both contexts with random gaps and checks every
// decoded result, in order, against a cycle-free predictor of the decoder.
// ============================================================================
module zstring_text_decoder_tb
    import zstd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The run is cut off here if it has not finished.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Number of random words after the directed part.
    localparam int unsigned RANDOM_WORDS = 260;
    // Cycles to keep watching the output once nothing more is expected.
    localparam int unsigned DRAIN_CYCLES = 8;

    // Named codes that the package does not spell out directly.
    localparam logic [4:0] Z_SHIFT1 = CODE_SHIFT_BASE + 5'd1;
    localparam logic [4:0] Z_SHIFT2 = CODE_SHIFT_MAX;
    localparam logic [4:0] Z_ABBR1  = CODE_ABBREV_LO;
    localparam logic [4:0] Z_ABBR2  = CODE_ABBREV_LO + 5'd1;
    localparam logic [4:0] Z_ABBR3  = CODE_ABBREV_MAX;
    localparam logic [4:0] Z_MAXCODE = 5'd31;

    // One input word as queued for the driver.
    typedef struct {
        logic [15:0] word;
        logic        ctx;
    } text_word_t;

    // One decoded character as the output port shows it.
    typedef struct {
        t_kind      kind;
        logic [9:0] value;
        logic       last;
        logic       fin;
    } zchar_t;

    // Decoder state of one context, kept by the predictor.
    typedef struct {
        logic [1:0] tshift;
        logic [1:0] lshift;
        logic       abbr_wait;
        logic [1:0] abbr_bank;
        logic [1:0] lit_phase;
        logic [4:0] lit_hi;
    } zstate_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_text_word = 16'h0000;
    logic        i_context_req = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [9:0]  o_value;
    logic        o_last;
    logic        o_string_end;

    text_word_t  pending_words[$];
    zchar_t      expected_chars[$];
    zstate_t     ctx_st[2];

    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned err_count = 0;
    bit          steady = 1'b0;

    zstring_text_decoder #(
        .NUM_CONTEXTS(2)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_text_word  (i_text_word),
        .i_context_req(i_context_req),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_last       (o_last),
        .o_string_end (o_string_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Returns a context to its reset state.
    function automatic void clear_state(input logic cx);
        ctx_st[cx].tshift    = SET_0;
        ctx_st[cx].lshift    = SET_0;
        ctx_st[cx].abbr_wait = 1'b0;
        ctx_st[cx].abbr_bank = 2'd0;
        ctx_st[cx].lit_phase = PHASE_IDLE;
        ctx_st[cx].lit_hi    = 5'd0;
    endfunction

    // Decodes one 5-bit code against the state of context cx, updating it.
    // The rules are checked in priority order: a pending abbreviation, then
    // a literal in progress, then the code itself.
    function automatic void zchar_decode(input logic cx, input logic [4:0] code,
                                         output t_kind kind, output logic [9:0] val);
        logic [1:0] cset;
        logic [1:0] target;
        // A set value of 3 is never stored, but would read as set 2.
        cset = (ctx_st[cx].tshift == SET_RSV) ? SET_2 : ctx_st[cx].tshift;
        kind = KIND_NONE;
        val  = 10'd0;
        if (ctx_st[cx].abbr_wait) begin
            // The code after a bank code completes the abbreviation number.
            val  = {3'd0, ctx_st[cx].abbr_bank, code};
            kind = KIND_ABBREV;
            ctx_st[cx].abbr_wait = 1'b0;
            ctx_st[cx].tshift    = ctx_st[cx].lshift;
        end else if (ctx_st[cx].lit_phase == PHASE_HIGH) begin
            ctx_st[cx].lit_hi    = code;
            ctx_st[cx].lit_phase = PHASE_LOW;
        end else if (ctx_st[cx].lit_phase != PHASE_IDLE) begin
            // Phase 3 is never stored; were it present it acts as the low half.
            val  = {ctx_st[cx].lit_hi, code};
            kind = KIND_LITERAL;
            ctx_st[cx].lit_phase = PHASE_IDLE;
            ctx_st[cx].tshift    = ctx_st[cx].lshift;
        end else if (code == CODE_SPACE) begin
            kind = KIND_SPACE;
            ctx_st[cx].tshift = ctx_st[cx].lshift;
        end else if (code <= CODE_ABBREV_MAX) begin
            ctx_st[cx].abbr_wait = 1'b1;
            ctx_st[cx].abbr_bank = 2'(code - CODE_ABBREV_LO);
        end else if (code <= CODE_SHIFT_MAX) begin
            // From set 0 a shift is temporary. From set 1 or 2 it locks:
            // the same shift keeps the set, the other one goes back to set 0.
            target = 2'(code - CODE_SHIFT_BASE);
            if (cset == SET_0) begin
                ctx_st[cx].tshift = target;
            end else begin
                if (cset != target) cset = SET_0;
                ctx_st[cx].tshift = cset;
                ctx_st[cx].lshift = cset;
            end
        end else if (cset == SET_2 && code == CODE_LITERAL) begin
            ctx_st[cx].lit_phase = PHASE_HIGH;
        end else if (cset == SET_2 && code == CODE_NEWLINE) begin
            kind = KIND_NEWLINE;
            ctx_st[cx].tshift = ctx_st[cx].lshift;
        end else begin
            val  = 10'(int'(cset) * ALPHA_LEN + int'(code) - int'(CODE_LITERAL));
            kind = KIND_ALPHA;
            ctx_st[cx].tshift = ctx_st[cx].lshift;
        end
    endfunction

    // Decodes a whole accepted word and queues its three characters.
    function automatic void decode_text_word(input logic [15:0] word, input logic cx);
        zchar_t     ch;
        t_kind      kind;
        logic [9:0] val;
        for (int k = 0; k < CODES_PER_WORD; k++) begin
            zchar_decode(cx, word[14 - 5 * k -: 5], kind, val);
            ch.kind  = kind;
            ch.value = val;
            ch.last  = (k == int'(SLOT_LAST));
            ch.fin   = word[15];
            expected_chars.push_back(ch);
        end
        // The end-of-string word is decoded first, then its context resets.
        if (word[15]) clear_state(cx);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [15:0] pack_word(input logic fin, input logic [4:0] a,
                                              input logic [4:0] b, input logic [4:0] c);
        return {fin, a, b, c};
    endfunction

    function automatic void add_word(input logic [15:0] word, input logic cx);
        text_word_t tw;
        tw.word = word;
        tw.ctx  = cx;
        pending_words.push_back(tw);
    endfunction

    // Picks a code with a bias toward the ones that open multi-code sequences,
    // so that abbreviations, literals and shifts show up often.
    function automatic logic [4:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return 5'($urandom_range(CODE_LITERAL, Z_MAXCODE));
        if (r < 45) return CODE_SPACE;
        if (r < 55) return 5'($urandom_range(Z_ABBR1, Z_ABBR3));
        if (r < 70) return 5'($urandom_range(Z_SHIFT1, Z_SHIFT2));
        if (r < 80) return CODE_LITERAL;
        if (r < 88) return CODE_NEWLINE;
        return 5'($urandom_range(0, Z_MAXCODE));
    endfunction

    // Gap length for either side: mostly none or short, a few long, and
    // now and then a stretch with no gaps at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if ($urandom_range(0, 39) == 0) steady = !steady;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued words on the input channel. A new word is
    // loaded only when the slot is free, that is when nothing is held or the
    // held word is being accepted at this edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        text_word_t tw;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_text_word(i_text_word, i_context_req);
            end
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_words.size() != 0) begin
                    tw = pending_words.pop_front();
                    i_valid       <= 1'b1;
                    i_text_word   <= tw.word;
                    i_context_req <= tw.ctx;
                    send_gap      <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stalls the output channel at random and checks each accepted
    // result against the oldest expected character.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        zchar_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d value=%0d last=%0b end=%0b",
                             $time, o_kind, o_value, o_last, o_string_end);
                    err_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_kind !== want.kind || o_value !== want.value ||
                        o_last !== want.last || o_string_end !== want.fin) begin
                        $display({"%0t: mismatch, expected kind=%0d value=%0d last=%0b",
                                  " end=%0b, got kind=%0d value=%0d last=%0b end=%0b"},
                                 $time, want.kind, want.value, want.last, want.fin,
                                 o_kind, o_value, o_last, o_string_end);
                        err_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                i_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) stall_left <= pick_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Word list, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n_words;
        int unsigned len;
        logic        cx;
        logic        closes;

        clear_state(1'b0);
        clear_state(1'b1);

        // Directed words. Comments give what the decoder should produce.
        // All spaces, then the largest code three times in set 0.
        add_word(pack_word(1'b0, CODE_SPACE, CODE_SPACE, CODE_SPACE), 1'b0);
        add_word(16'h7FFF, 1'b0);
        // Abbreviation in bank 0, then bank 1 left pending across the word.
        add_word(pack_word(1'b0, Z_ABBR1, 5'd31, Z_ABBR2), 1'b0);
        // The pending one completes with code 0; bank 2 gives number 95.
        add_word(pack_word(1'b0, CODE_SPACE, Z_ABBR3, 5'd31), 1'b0);
        // Temporary shift to set 1, a letter, temporary shift to set 2.
        add_word(pack_word(1'b0, Z_SHIFT1, CODE_LITERAL, Z_SHIFT2), 1'b0);
        // Literal from set 2, high 12 and low 31, and the string ends here.
        add_word(pack_word(1'b1, CODE_LITERAL, 5'd12, 5'd31), 1'b0);
        // Newline in set 2, then a temporary shift carried into the next word.
        add_word(pack_word(1'b0, Z_SHIFT2, CODE_NEWLINE, Z_SHIFT1), 1'b0);
        // Same shift from set 1 locks set 1; a letter; lock again.
        add_word(pack_word(1'b0, Z_SHIFT1, CODE_LITERAL, Z_SHIFT1), 1'b0);
        // Other shift from locked set 1 drops back to set 0, a letter, a space.
        add_word(pack_word(1'b0, Z_SHIFT2, 5'd10, CODE_SPACE), 1'b0);
        // Lock set 2, then start a literal that spans into the next word.
        add_word(pack_word(1'b0, Z_SHIFT2, Z_SHIFT2, CODE_LITERAL), 1'b0);
        // Largest literal, then a newline in locked set 2.
        add_word(pack_word(1'b0, 5'd31, 5'd31, CODE_NEWLINE), 1'b0);
        // Smallest literal.
        add_word(pack_word(1'b0, CODE_LITERAL, CODE_SPACE, CODE_SPACE), 1'b0);
        // The abbreviation context, interleaved: its state is separate.
        add_word(pack_word(1'b0, Z_ABBR2, Z_SHIFT2, Z_SHIFT1), 1'b1);
        add_word(pack_word(1'b0, 5'd8, Z_SHIFT2, CODE_LITERAL), 1'b0);
        // An abbreviation reference made while expanding an abbreviation.
        add_word(pack_word(1'b0, Z_ABBR1, Z_ABBR1, 5'd9), 1'b1);
        // Literal halves of the outer string, a space, and the string ends.
        add_word(pack_word(1'b1, Z_ABBR3, CODE_SPACE, CODE_SPACE), 1'b0);
        add_word(16'hFFFF, 1'b0);
        add_word(16'hFFFF, 1'b1);
        add_word(pack_word(1'b0, CODE_LITERAL, CODE_LITERAL, CODE_NEWLINE), 1'b1);
        add_word(16'h8000, 1'b1);
        // End of string with a lock and a pending abbreviation: both cleared.
        add_word(pack_word(1'b1, Z_SHIFT2, Z_SHIFT2, Z_ABBR1), 1'b0);
        add_word(pack_word(1'b0, 5'd31, 5'd31, 5'd31), 1'b0);

        // Random part: mostly whole strings built from biased codes, with
        // some fully random words on either context mixed in as noise.
        n_words = 0;
        while (n_words < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_word(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
                n_words++;
            end else begin
                len    = $urandom_range(1, 6);
                cx     = 1'($urandom_range(0, 1));
                closes = ($urandom_range(0, 6) != 0);
                for (int w = 0; w < len; w++) begin
                    add_word(pack_word(closes && (w == len - 1),
                                       pick_code(), pick_code(), pick_code()), cx);
                end
                n_words += len;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to be taken and every result to come back,
        // then watch a few more cycles for stray results.
        while (pending_words.size() != 0 || i_valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> zstring_text_decoder.f
+incdir+design
design/zstd_pkg.sv
design/zstd_code_step.sv
design/zstd_ctx_regs.sv
design/zstd_out_ser.sv
design/zstring_text_decoder.sv
bench/zstring_text_decoder_tb.sv
